/* rtl/hbp_pkg.sv */
// hbp_pkg: shared constants, types and sizes for the hybrid branch predictor
// used by every module under rtl/; depends on nothing else
package hbp_pkg;

  localparam int GSHARE_INDEX_BITS  = 12;
  localparam int HISTORY_BITS       = 8;
  localparam int BIMODAL_INDEX_BITS = 12;
  localparam int CHOOSER_INDEX_BITS = 8;

  localparam int PC_BITS    = 24;
  localparam int COUNT_BITS = 32;
  localparam int CTR_BITS   = 3;
  localparam int CHO_BITS   = 2;

  localparam int GSH_DEPTH = 1 << GSHARE_INDEX_BITS;
  localparam int BIM_DEPTH = 1 << BIMODAL_INDEX_BITS;
  localparam int CHO_DEPTH = 1 << CHOOSER_INDEX_BITS;

  // the clearing sweep covers the largest table
  localparam int CLR_BITS_GB = (GSHARE_INDEX_BITS > BIMODAL_INDEX_BITS) ?
                               GSHARE_INDEX_BITS : BIMODAL_INDEX_BITS;
  localparam int CLR_BITS    = (CLR_BITS_GB > CHOOSER_INDEX_BITS) ?
                               CLR_BITS_GB : CHOOSER_INDEX_BITS;

  localparam logic [CTR_BITS-1:0] CTR_INIT      = CTR_BITS'(4);
  localparam logic [CTR_BITS-1:0] CTR_MAX       = CTR_BITS'(7);
  localparam logic [CTR_BITS-1:0] CTR_TAKEN_MIN = CTR_BITS'(4);
  localparam logic [CHO_BITS-1:0] CHO_INIT      = CHO_BITS'(1);
  localparam logic [CHO_BITS-1:0] CHO_MAX       = CHO_BITS'(3);
  localparam logic [CHO_BITS-1:0] CHO_GSH_MIN   = CHO_BITS'(2);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;

  typedef logic [BIMODAL_INDEX_BITS-1:0] bim_idx_t;
  typedef logic [GSHARE_INDEX_BITS-1:0]  gsh_idx_t;
  typedef logic [CHOOSER_INDEX_BITS-1:0] cho_idx_t;
  typedef logic [HISTORY_BITS-1:0]       hist_t;
  typedef logic [CTR_BITS-1:0]           ctr_t;
  typedef logic [CHO_BITS-1:0]           cho_t;
  typedef logic [COUNT_BITS-1:0]         count_t;

  // one classified branch on its way from the front to the back
  typedef struct packed {
    bim_idx_t bim_idx;
    gsh_idx_t gsh_idx;
    cho_idx_t cho_idx;
    logic     taken;
  } branch_item_t;

  typedef struct packed {
    count_t branch_total;
    count_t mispredict_total;
    logic   mispredicted;
    logic   chose_gshare;
    logic   predicted_taken;
  } pred_result_t;

endpackage

/* rtl/hybrid_branch_predictor_unit.sv */
// Tournament branch predictor (bimodal + gshare with a per-pc chooser). Each
// input transaction carries one resolved branch and yields exactly one result
// transaction. The unit sustains one branch per cycle unless the output stalls
// or the sweep runs: the front computes the table indexes and shifts the global
// history at accept, a four-entry queue decouples it from the back, which reads
// all three tables into its lookup register and trains the chooser and chosen
// counter as the result register loads, forwarding a same-edge write. After
// reset the tables are swept to their initial values one entry per cycle over
// the largest table's indexes, during which in_tready stays low.
// Depends on hbp_pkg, hbp_front, hbp_queue and hbp_back.
module hybrid_branch_predictor_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hbp_pkg::IN_TDATA_W-1:0]     in_tdata,   // branch_pc[23:0], taken[24]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // predicted_taken[0], chose_gshare[1], mispredicted[2], mispredict_total[34:3],
  // branch_total[66:35]
  output logic [hbp_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic                  push_valid, push_ready, q_valid, q_pop, clearing;
  hbp_pkg::branch_item_t push_item, q_item;
  hbp_pkg::pred_result_t result;

  hbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .branch_pc  (in_tdata[hbp_pkg::PC_BITS-1:0]),
    .taken      (in_tdata[hbp_pkg::PC_BITS]),
    .clearing   (clearing),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  hbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  hbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (result)
  );

  assign out_tdata = {{(hbp_pkg::OUT_TDATA_W - $bits(hbp_pkg::pred_result_t)){1'b0}},
                      result};

endmodule

/* rtl/hbp_front.sv */
// hbp_front: accepts branches, derives the three table indexes and keeps the
// global history; depends on hbp_pkg
module hbp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [hbp_pkg::PC_BITS-1:0] branch_pc,
  input  logic                       taken,
  input  logic                       clearing,
  input  logic                       push_ready,
  output logic                       push_valid,
  output hbp_pkg::branch_item_t      push_item
);

  hbp_pkg::hist_t hist_r, hist_nxt;
  logic           accept;
  logic [hbp_pkg::GSHARE_INDEX_BITS+hbp_pkg::HISTORY_BITS-1:0] hist_ext;

  assign in_tready  = push_ready && !clearing;
  assign push_valid = in_tvalid && !clearing;
  assign accept     = in_tvalid && in_tready;

  // history is zero-extended or truncated to the gshare index width
  assign hist_ext = {{hbp_pkg::GSHARE_INDEX_BITS{1'b0}}, hist_r};

  always_comb begin
    push_item.bim_idx = branch_pc[hbp_pkg::BIMODAL_INDEX_BITS+1:2];
    push_item.cho_idx = branch_pc[hbp_pkg::CHOOSER_INDEX_BITS+1:2];
    push_item.gsh_idx = branch_pc[hbp_pkg::GSHARE_INDEX_BITS+1:2] ^
                        hist_ext[hbp_pkg::GSHARE_INDEX_BITS-1:0];
    push_item.taken   = taken;
  end

  // newest outcome enters at the msb
  assign hist_nxt = (hist_r >> 1) |
                    (hbp_pkg::hist_t'(taken) << (hbp_pkg::HISTORY_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (accept) begin
      hist_r <= hist_nxt;
    end
  end

endmodule

/* rtl/hbp_queue.sv */
// hbp_queue: short fifo of classified branches between front and back
// depends on hbp_pkg
module hbp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  hbp_pkg::branch_item_t push_item,
  output logic                  pop_valid,
  input  logic                  pop,
  output hbp_pkg::branch_item_t pop_item
);

  hbp_pkg::branch_item_t       slots_r [hbp_pkg::QUEUE_DEPTH];
  logic [hbp_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [hbp_pkg::QUEUE_AW:0]   count_r, count_nxt;
  logic                         do_push, do_pop;

  assign push_ready = (count_r != (hbp_pkg::QUEUE_AW+1)'(hbp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (hbp_pkg::QUEUE_AW+1)'(hbp_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> rd_ptr_r == $past(rd_ptr_r) + 1'b1)
    else $error("queue read pointer did not advance on pop");

endmodule

/* rtl/hbp_back.sv */
// hbp_back: table lookup, training, chooser update and running totals, with
// the result register and the reset clearing sweep; depends on hbp_pkg
module hbp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  hbp_pkg::branch_item_t q_item,
  output logic                  clearing,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output hbp_pkg::pred_result_t out_result
);

  // tables
  hbp_pkg::ctr_t bim_mem [hbp_pkg::BIM_DEPTH];
  hbp_pkg::ctr_t gsh_mem [hbp_pkg::GSH_DEPTH];
  hbp_pkg::cho_t cho_mem [hbp_pkg::CHO_DEPTH];

  logic                           clearing_r;
  logic [hbp_pkg::CLR_BITS-1:0]   clr_addr_r;

  // lookup stage
  logic                  b_valid_r;
  hbp_pkg::branch_item_t b_item_r;
  hbp_pkg::ctr_t         bim_rd_r, gsh_rd_r, bim_byp_data_r, gsh_byp_data_r;
  hbp_pkg::cho_t         cho_rd_r, cho_byp_data_r;
  logic                  bim_byp_r, gsh_byp_r, cho_byp_r;

  // result register and totals
  logic                  out_valid_r;
  hbp_pkg::pred_result_t out_r;
  hbp_pkg::count_t       mis_cnt_r, mis_cnt_nxt, br_cnt_r, br_cnt_nxt;

  // write ports
  logic                  bim_we, gsh_we, cho_we;
  hbp_pkg::bim_idx_t     bim_wa;
  hbp_pkg::gsh_idx_t     gsh_wa;
  hbp_pkg::cho_idx_t     cho_wa;
  hbp_pkg::ctr_t         bim_wd, gsh_wd;
  hbp_pkg::cho_t         cho_wd;

  hbp_pkg::ctr_t         bim_cur, gsh_cur, ctr_sel, ctr_trained;
  hbp_pkg::cho_t         cho_cur, cho_new;
  logic                  bp, gp, use_g, pred, miss;
  logic                  out_load, b_adv;

  assign clearing   = clearing_r;
  assign out_tvalid = out_valid_r;
  assign out_result = out_r;

  assign out_load = b_valid_r && (!out_valid_r || out_tready);
  assign b_adv    = !b_valid_r || out_load;
  assign q_pop    = q_valid && b_adv && !clearing_r;

  // a write landing on the same edge as the read is forwarded
  assign bim_cur = bim_byp_r ? bim_byp_data_r : bim_rd_r;
  assign gsh_cur = gsh_byp_r ? gsh_byp_data_r : gsh_rd_r;
  assign cho_cur = cho_byp_r ? cho_byp_data_r : cho_rd_r;

  always_comb begin
    bp    = (bim_cur >= hbp_pkg::CTR_TAKEN_MIN);
    gp    = (gsh_cur >= hbp_pkg::CTR_TAKEN_MIN);
    use_g = (cho_cur >= hbp_pkg::CHO_GSH_MIN);
    pred  = use_g ? gp : bp;
    miss  = (pred != b_item_r.taken);

    ctr_sel     = use_g ? gsh_cur : bim_cur;
    ctr_trained = ctr_sel;
    if (b_item_r.taken) begin
      if (ctr_sel != hbp_pkg::CTR_MAX) begin
        ctr_trained = ctr_sel + 1'b1;
      end
    end else if (ctr_sel != '0) begin
      ctr_trained = ctr_sel - 1'b1;
    end

    // move toward whichever predictor alone was right
    cho_new = cho_cur;
    if ((bp != b_item_r.taken) && (gp == b_item_r.taken) &&
        (cho_cur != hbp_pkg::CHO_MAX)) begin
      cho_new = cho_cur + 1'b1;
    end else if ((bp == b_item_r.taken) && (gp != b_item_r.taken) &&
                 (cho_cur != '0)) begin
      cho_new = cho_cur - 1'b1;
    end

    mis_cnt_nxt = mis_cnt_r + hbp_pkg::count_t'(miss);
    br_cnt_nxt  = br_cnt_r + 1'b1;
  end

  always_comb begin
    if (clearing_r) begin
      bim_we = 1'b1;
      gsh_we = 1'b1;
      cho_we = 1'b1;
      bim_wa = clr_addr_r[hbp_pkg::BIMODAL_INDEX_BITS-1:0];
      gsh_wa = clr_addr_r[hbp_pkg::GSHARE_INDEX_BITS-1:0];
      cho_wa = clr_addr_r[hbp_pkg::CHOOSER_INDEX_BITS-1:0];
      bim_wd = hbp_pkg::CTR_INIT;
      gsh_wd = hbp_pkg::CTR_INIT;
      cho_wd = hbp_pkg::CHO_INIT;
    end else begin
      bim_we = out_load && !use_g;
      gsh_we = out_load && use_g;
      cho_we = out_load;
      bim_wa = b_item_r.bim_idx;
      gsh_wa = b_item_r.gsh_idx;
      cho_wa = b_item_r.cho_idx;
      bim_wd = ctr_trained;
      gsh_wd = ctr_trained;
      cho_wd = cho_new;
    end
  end

  always_ff @(posedge clk) begin
    if (bim_we) begin
      bim_mem[bim_wa] <= bim_wd;
    end
    if (q_pop) begin
      bim_rd_r <= bim_mem[q_item.bim_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (gsh_we) begin
      gsh_mem[gsh_wa] <= gsh_wd;
    end
    if (q_pop) begin
      gsh_rd_r <= gsh_mem[q_item.gsh_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cho_we) begin
      cho_mem[cho_wa] <= cho_wd;
    end
    if (q_pop) begin
      cho_rd_r <= cho_mem[q_item.cho_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_item_r       <= q_item;
      bim_byp_r      <= bim_we && (bim_wa == q_item.bim_idx);
      gsh_byp_r      <= gsh_we && (gsh_wa == q_item.gsh_idx);
      cho_byp_r      <= cho_we && (cho_wa == q_item.cho_idx);
      bim_byp_data_r <= bim_wd;
      gsh_byp_data_r <= gsh_wd;
      cho_byp_data_r <= cho_wd;
    end
    if (out_load) begin
      out_r.predicted_taken  <= pred;
      out_r.chose_gshare     <= use_g;
      out_r.mispredicted     <= miss;
      out_r.mispredict_total <= mis_cnt_nxt;
      out_r.branch_total     <= br_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      mis_cnt_r   <= '0;
      br_cnt_r    <= '0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          clearing_r <= 1'b0;
        end
      end
      if (b_adv) begin
        b_valid_r <= q_pop;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        mis_cnt_r   <= mis_cnt_nxt;
        br_cnt_r    <= br_cnt_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !b_valid_r && !q_pop)
    else $error("branch in flight during table clearing");

  a_branch_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> br_cnt_r == $past(br_cnt_r) + 1'b1)
    else $error("branch total did not advance with result");

  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(br_cnt_r) && $stable(mis_cnt_r))
    else $error("totals changed without a result");

  a_result_matches_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_r.branch_total == br_cnt_r &&
                 out_r.mispredict_total == mis_cnt_r)
    else $error("result totals differ from running totals");

endmodule

/* sim/hybrid_branch_predictor_unit_test.sv */
// testbench for hybrid_branch_predictor_unit: drives resolved branches, runs a
// tournament predictor alongside the block and compares every result transaction
// depends on rtl/hbp_pkg.sv and the rtl under rtl/
`timescale 1ns / 1ps

module hybrid_branch_predictor_unit_test;
  import hbp_pkg::*;

  localparam int POOL_SIZE = 16;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  hybrid_branch_predictor_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // shadow copy of the predictor state
  ctr_t   bimodal_ctr [BIM_DEPTH];
  ctr_t   gshare_ctr  [GSH_DEPTH];
  cho_t   chooser_ctr [CHO_DEPTH];
  hist_t  history;
  count_t miss_count;
  count_t branch_count;

  pred_result_t pending_predictions[$];
  int           mismatch_count = 0;

  // flow control shared by the sender, the receiver and the tests
  // a hold-off is requested by toggling hold_req, the receiver answers in hold_ack
  logic steady   = 1'b0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  // branch pool with repeating outcome patterns so gshare and the chooser get exercised
  logic [PC_BITS-1:0] pool_pc  [POOL_SIZE];
  logic [7:0]         pool_pat [POOL_SIZE];
  int                 pool_len [POOL_SIZE];
  int                 pool_pos [POOL_SIZE];

  function automatic ctr_t train_ctr(ctr_t c, logic tk);
    if (tk) begin
      return (c == CTR_MAX) ? c : c + 1'b1;
    end
    return (c == '0) ? c : c - 1'b1;
  endfunction

  task automatic predict_branch(input logic [PC_BITS-1:0] pc, input logic tk);
    bim_idx_t     bi;
    gsh_idx_t     gi;
    cho_idx_t     ci;
    logic         bim_says;
    logic         gsh_says;
    logic         use_gsh;
    pred_result_t r;
    bi = pc[BIMODAL_INDEX_BITS+1:2];
    gi = pc[GSHARE_INDEX_BITS+1:2] ^ gsh_idx_t'(history);
    ci = pc[CHOOSER_INDEX_BITS+1:2];
    bim_says = bimodal_ctr[bi] >= CTR_TAKEN_MIN;
    gsh_says = gshare_ctr[gi] >= CTR_TAKEN_MIN;
    use_gsh  = chooser_ctr[ci] >= CHO_GSH_MIN;
    r.predicted_taken = use_gsh ? gsh_says : bim_says;
    r.chose_gshare    = use_gsh;
    r.mispredicted    = r.predicted_taken != tk;
    if (use_gsh) begin
      gshare_ctr[gi] = train_ctr(gshare_ctr[gi], tk);
    end else begin
      bimodal_ctr[bi] = train_ctr(bimodal_ctr[bi], tk);
    end
    history = {tk, history[HISTORY_BITS-1:1]};
    // chooser leans toward whichever side alone got it right
    if (bim_says != tk && gsh_says == tk && chooser_ctr[ci] != CHO_MAX) begin
      chooser_ctr[ci] = chooser_ctr[ci] + 1'b1;
    end
    if (bim_says == tk && gsh_says != tk && chooser_ctr[ci] != '0) begin
      chooser_ctr[ci] = chooser_ctr[ci] - 1'b1;
    end
    if (r.mispredicted) begin
      miss_count = miss_count + 1'b1;
    end
    branch_count = branch_count + 1'b1;
    r.mispredict_total = miss_count;
    r.branch_total     = branch_count;
    pending_predictions.push_back(r);
  endtask

  task automatic send_branch(input logic [PC_BITS-1:0] pc, input logic tk);
    if (!steady) begin
      while ($urandom_range(99) < 25) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({tk, pc});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_branch(pc, tk);
  endtask

  task automatic send_pool_branch(input int k);
    send_branch(pool_pc[k], pool_pat[k][pool_pos[k]]);
    pool_pos[k] = (pool_pos[k] + 1) % pool_len[k];
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_left = 120;
      hold_ack  = hold_req;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 25);
    end
  end

  // result checker
  always @(posedge clk) begin
    pred_result_t want;
    pred_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = pred_result_t'(out_tdata[$bits(pred_result_t)-1:0]);
      if (pending_predictions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result transaction: tdata=%h", out_tdata);
        end
      end else begin
        want = pending_predictions.pop_front();
        if (got !== want || out_tdata[OUT_TDATA_W-1:$bits(pred_result_t)] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d: expected pred=%b gsh=%b miss=%b misses=%0d branches=%0d",
                     want.branch_total, want.predicted_taken, want.chose_gshare,
                     want.mispredicted, want.mispredict_total, want.branch_total);
            $display("  actual pred=%b gsh=%b miss=%b misses=%0d branches=%0d pad=%h",
                     got.predicted_taken, got.chose_gshare, got.mispredicted,
                     got.mispredict_total, got.branch_total,
                     out_tdata[OUT_TDATA_W-1:$bits(pred_result_t)]);
          end
        end
      end
    end
  end

  task automatic test_pc_extremes;
    send_branch(24'h000000, 1'b0);
    send_branch(24'hFFFFFF, 1'b1);
    send_branch(24'hAAAAAA, 1'b1);
    send_branch(24'h555555, 1'b0);
  endtask

  // drive one counter into both saturation limits
  task automatic test_counter_saturation;
    repeat (4) send_branch(24'h000100, 1'b1);
    repeat (8) send_branch(24'h000100, 1'b0);
  endtask

  // alternating outcomes defeat bimodal and move the chooser toward gshare
  task automatic test_chooser_training;
    for (int i = 0; i < 8; i++) begin
      send_branch(24'h3C0208, i[0]);
    end
  endtask

  task automatic test_pattern_stream(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 75) begin
        send_pool_branch($urandom_range(POOL_SIZE-1));
      end else begin
        send_branch(PC_BITS'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_full_rate(input int n);
    steady = 1'b1;
    test_pattern_stream(n);
    steady = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure(input int n);
    hold_req = ~hold_req;
    test_pattern_stream(n);
  endtask

  initial begin
    for (int i = 0; i < BIM_DEPTH; i++) bimodal_ctr[i] = CTR_INIT;
    for (int i = 0; i < GSH_DEPTH; i++) gshare_ctr[i] = CTR_INIT;
    for (int i = 0; i < CHO_DEPTH; i++) chooser_ctr[i] = CHO_INIT;
    history      = '0;
    miss_count   = '0;
    branch_count = '0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      // half the pool aliases into a narrow range of table entries
      pool_pc[k]  = (k < POOL_SIZE / 2) ? PC_BITS'($urandom) :
                    PC_BITS'({$urandom_range(63), 2'b00});
      pool_pat[k] = 8'($urandom);
      pool_len[k] = $urandom_range(1, 8);
      pool_pos[k] = 0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_pc_extremes();
    test_counter_saturation();
    test_chooser_training();
    test_pattern_stream(900);
    test_full_rate(100);
    test_backpressure(80);
    in_tvalid <= 1'b0;

    while (pending_predictions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_predictions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
